// ----- src/twa_pkg.sv -----
`default_nettype none
package twa_pkg;
   localparam int TileW = 64;
   localparam int TileH = 64;
   localparam int MaxReach = 8;
   localparam int AddrW = 12;
   localparam int SumW = 25;
   localparam int CntW = 9;
   localparam logic [15:0] OneQ412 = 16'd4096;

   localparam logic [1:0] CSR_REACH = 2'd0;
   localparam logic [1:0] CSR_STEP = 2'd1;
   localparam logic [1:0] CSR_THRESH = 2'd2;

   typedef struct packed {
      logic start;
      logic write;
      logic centre;
      logic scan;
      logic div_start;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic div_done;
   } status_type;
endpackage
`default_nettype wire

// ----- src/twa_datapath.sv -----
`default_nettype none
module twa_datapath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire twa_pkg::cmd_type   cmd,
   output twa_pkg::status_type     status,
   input  wire logic [126:0]       req_item,
   input  wire logic [3:0]         reach_cfg,
   input  wire logic [2:0]         step_cfg,
   input  wire logic [17:0]        thresh_cfg,
   output logic [15:0]             res_red,
   output logic [15:0]             res_green,
   output logic [15:0]             res_blue,
   output logic [15:0]             res_alpha,
   output logic [8:0]              res_count
);
   logic [63:0] color_mem [0:4095];
   logic [47:0] guide_mem [0:4095];
   logic [63:0] color_rd_ff;
   logic [47:0] guide_rd_ff;

   logic [5:0] px_ff, py_ff;
   logic signed [7:0] xi_ff, yi_ff, xi_in, yi_in;
   logic [3:0] reach;
   logic [2:0] step;
   logic rd_valid_ff, rd_in_tile_ff, gen_done_ff;
   logic [47:0] centre_ff;
   logic [24:0] sum_ff [4];
   logic [8:0] cnt_ff;
   logic pend_ff;
   logic in_tile;
   logic [11:0] rd_addr;

   assign reach = (reach_cfg > 4'(twa_pkg::MaxReach)) ? 4'(twa_pkg::MaxReach) : reach_cfg;
   assign step = (step_cfg == 3'd0) ? 3'd1 : step_cfg;
   assign in_tile = (xi_ff >= 0) && (yi_ff >= 0) && (xi_ff < twa_pkg::TileW) &&
                    (yi_ff < twa_pkg::TileH);
   assign rd_addr = {yi_ff[5:0], xi_ff[5:0]};

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         color_mem[{req_item[12:7], req_item[6:1]}] <= req_item[76:13];
         guide_mem[{req_item[12:7], req_item[6:1]}] <= req_item[124:77];
      end
      if (cmd.start) begin
         color_rd_ff <= color_mem[{req_item[12:7], req_item[6:1]}];
         guide_rd_ff <= guide_mem[{req_item[12:7], req_item[6:1]}];
      end else begin
         color_rd_ff <= color_mem[rd_addr];
         guide_rd_ff <= guide_mem[rd_addr];
      end
   end

   // Window walk: one position a cycle; the memory read is registered and lands in the following cycle.
   always_comb begin
      xi_in = xi_ff + 8'(step);
      yi_in = yi_ff;
      if (xi_in >= $signed({2'b0, px_ff}) + $signed({4'b0, reach})) begin
         xi_in = $signed({2'b0, px_ff}) - $signed({4'b0, reach});
         yi_in = yi_ff + 8'(step);
      end
   end

   logic [16:0] d0, d1, d2;
   logic [17:0] l1_dist;
   always_comb begin
      logic [15:0] g0, g1, g2;
      g0 = rd_in_tile_ff ? guide_rd_ff[15:0] : 16'd0;
      g1 = rd_in_tile_ff ? guide_rd_ff[31:16] : 16'd0;
      g2 = rd_in_tile_ff ? guide_rd_ff[47:32] : 16'd0;
      d0 = (centre_ff[15:0] > g0) ? 17'(centre_ff[15:0] - g0) : 17'(g0 - centre_ff[15:0]);
      d1 = (centre_ff[31:16] > g1) ? 17'(centre_ff[31:16] - g1) : 17'(g1 - centre_ff[31:16]);
      d2 = (centre_ff[47:32] > g2) ? 17'(centre_ff[47:32] - g2) : 17'(g2 - centre_ff[47:32]);
      l1_dist = 18'(d0) + 18'(d1) + 18'(d2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         gen_done_ff <= 1'b1;
         pend_ff <= 1'b0;
      end else begin
         if (cmd.start) begin
            px_ff <= req_item[6:1];
            py_ff <= req_item[12:7];
            xi_ff <= $signed({2'b0, req_item[6:1]}) - $signed({4'b0, reach});
            yi_ff <= $signed({2'b0, req_item[12:7]}) - $signed({4'b0, reach});
            gen_done_ff <= 1'b0;
            rd_valid_ff <= 1'b0;
            pend_ff <= 1'b0;
            cnt_ff <= '0;
            for (int c = 0; c < 4; c++) sum_ff[c] <= '0;
         end else if (cmd.centre) begin
            centre_ff <= guide_rd_ff;
            gen_done_ff <= (reach == 4'd0);
         end else if (cmd.scan) begin
            rd_valid_ff <= !gen_done_ff;
            rd_in_tile_ff <= in_tile;
            if (!gen_done_ff) begin
               xi_ff <= xi_in;
               yi_ff <= yi_in;
               if (yi_in >= $signed({2'b0, py_ff}) + $signed({4'b0, reach}))
                  gen_done_ff <= 1'b1;
            end
            pend_ff <= rd_valid_ff;
            if (rd_valid_ff && l1_dist < thresh_cfg) begin
               cnt_ff <= cnt_ff + 9'd1;
               if (rd_in_tile_ff)
                  for (int c = 0; c < 4; c++)
                     sum_ff[c] <= sum_ff[c] + 25'(color_rd_ff[16*c +: 16]);
            end
         end
      end
   end
   assign status.scan_done = gen_done_ff && !rd_valid_ff && !cmd.start && !cmd.centre;

   // Restoring divider, all four channels share one bit step per cycle.
   logic [24:0] quo_ff [4];
   logic [24:0] rem_ff [4];
   logic [4:0] bit_ff;
   logic busy_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         bit_ff <= '0;
      end else if (cmd.div_start) begin
         busy_ff <= (cnt_ff != 9'd0);
         bit_ff <= 5'd24;
         for (int c = 0; c < 4; c++) begin
            quo_ff[c] <= sum_ff[c];
            rem_ff[c] <= '0;
         end
      end else if (busy_ff) begin
         for (int c = 0; c < 4; c++) begin
            logic [25:0] r;
            r = {rem_ff[c], quo_ff[c][24]};
            if (r >= 26'(cnt_ff)) begin
               rem_ff[c] <= 25'(r - 26'(cnt_ff));
               quo_ff[c] <= {quo_ff[c][23:0], 1'b1};
            end else begin
               rem_ff[c] <= r[24:0];
               quo_ff[c] <= {quo_ff[c][23:0], 1'b0};
            end
         end
         if (bit_ff == 5'd0) busy_ff <= 1'b0;
         else bit_ff <= bit_ff - 5'd1;
      end
   end
   assign status.div_done = !busy_ff && !cmd.div_start;

   always_comb begin
      if (cnt_ff == 9'd0) begin
         res_red = '0; res_green = '0; res_blue = '0; res_alpha = twa_pkg::OneQ412;
      end else begin
         res_red = quo_ff[0][15:0];
         res_green = quo_ff[1][15:0];
         res_blue = quo_ff[2][15:0];
         res_alpha = quo_ff[3][15:0];
      end
      res_count = cnt_ff;
   end
   logic unused;
   assign unused = pend_ff ^ req_item[125] ^ req_item[126];
endmodule
`default_nettype wire

// ----- src/twa_control.sv -----
`default_nettype none
module twa_control (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic                 func,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic                      load_result,
   output logic                      zero_result,
   output twa_pkg::cmd_type          cmd,
   input  wire twa_pkg::status_type  status
);
   localparam logic [2:0] S_IDLE = 3'd0, S_CENTRE = 3'd1, S_SCAN = 3'd2,
                          S_DIV = 3'd3, S_WAIT = 3'd4, S_DONE = 3'd5;
   logic [2:0] state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic acc;

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign acc = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd = '0;
      load_result = 1'b0;
      zero_result = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (acc) begin
               if (!func) begin
                  cmd.write = 1'b1;
                  zero_result = 1'b1;
                  load_result = 1'b1;
                  rsp_valid_in = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in = S_CENTRE;
               end
            end
         end
         S_CENTRE: begin
            cmd.centre = 1'b1;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_start = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: if (status.div_done) state_in = S_DONE;
         S_DONE: begin
            load_result = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

// ----- src/thresholded_window_average.sv -----
// Write request: the response is valid in the cycle after acceptance.
// Filter request: after acceptance the block reads the centre guide, scans the N window
// positions (one tile read a cycle), then runs the bit-serial divider, which is skipped
// when no pixel matched; the scan is skipped when the reach is zero. One in flight.
// Synchronous active-high reset initialises control and config; tile memory is not cleared.
`default_nettype none
module thresholded_window_average (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // func, pos_x, pos_y, in_red, in_green, in_blue, in_alpha,
   // guide_red, guide_green, guide_blue (125 bits, zero-filled to 128)
   input  wire logic [127:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // out_red, out_green, out_blue, out_alpha, match_count (73 bits, to 80)
   output logic [79:0]       rsp_tdata,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [17:0]  csr_wdata
);
   logic [3:0] reach_ff;
   logic [2:0] step_ff;
   logic [17:0] thresh_ff;
   twa_pkg::cmd_type cmd;
   twa_pkg::status_type status;
   logic load_result, zero_result;
   logic [15:0] r, g, b, a;
   logic [8:0] n;
   logic [72:0] rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         reach_ff <= 4'd1;
         step_ff <= 3'd1;
         thresh_ff <= 18'd4096;
      end else if (csr_we) begin
         unique case (csr_index)
            twa_pkg::CSR_REACH: reach_ff <= csr_wdata[3:0];
            twa_pkg::CSR_STEP: step_ff <= csr_wdata[2:0];
            twa_pkg::CSR_THRESH: thresh_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   twa_control u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .func(req_tdata[0]), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .load_result(load_result), .zero_result(zero_result), .cmd(cmd), .status(status)
   );

   twa_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_item(req_tdata[126:0]), .reach_cfg(reach_ff), .step_cfg(step_ff),
      .thresh_cfg(thresh_ff), .res_red(r), .res_green(g), .res_blue(b),
      .res_alpha(a), .res_count(n)
   );

   always_ff @(posedge clock) begin
      if (load_result) rsp_ff <= zero_result ? '0 : {n, a, b, g, r};
   end
   assign rsp_tdata = {7'd0, rsp_ff};
   logic unused;
   assign unused = req_tdata[127];
endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
   typedef struct {
      logic        func;
      logic [5:0]  pos_x;
      logic [5:0]  pos_y;
      logic [15:0] color [4];
      logic [15:0] guide [3];
   } pixel_request_type;

   typedef struct {
      logic [15:0] chan [4];
      logic [8:0]  count;
   } average_result_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [127:0]  req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [79:0]   rsp_tdata;
   logic          csr_we = 1'b0;
   logic [1:0]    csr_index = twa_pkg::CSR_REACH;
   logic [17:0]   csr_wdata = '0;

   thresholded_window_average dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   pixel_request_type  pending_requests [$];
   pixel_request_type  current_request;
   average_result_type expected_averages [$];

   // Shadow copies of the tile and the registers.
   logic [15:0] shadow_color [twa_pkg::TileW*twa_pkg::TileH][4];
   logic [15:0] shadow_guide [twa_pkg::TileW*twa_pkg::TileH][3];
   int unsigned reach_reg = 1, step_reg = 1, threshold_reg = 4096;

   logic [15:0] palette [4][3];
   int          send_idle_pct = 8, recv_idle_pct = 69;
   int          error_count = 0;
   longint      cycle_count = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [127:0] pack_request(pixel_request_type r);
      logic [127:0] d;
      d = '0;
      d[0] = r.func;
      d[6:1] = r.pos_x;
      d[12:7] = r.pos_y;
      for (int c = 0; c < 4; c++) d[13 + 16*c +: 16] = r.color[c];
      for (int c = 0; c < 3; c++) d[77 + 16*c +: 16] = r.guide[c];
      return d;
   endfunction

   function automatic average_result_type compute_average(pixel_request_type r);
      average_result_type res;
      int px, py, rch, stp, idx;
      int unsigned l1_dist, cnt;
      int unsigned sums [4];
      logic [15:0] ctr [3];
      logic [15:0] g [3];
      res.chan = '{default: 16'd0};
      res.count = '0;
      if (!r.func) begin
         idx = r.pos_y * twa_pkg::TileW + r.pos_x;
         shadow_color[idx] = r.color;
         shadow_guide[idx] = r.guide;
         return res;
      end
      px = r.pos_x;
      py = r.pos_y;
      rch = (reach_reg > twa_pkg::MaxReach) ? twa_pkg::MaxReach : reach_reg;
      stp = (step_reg == 0) ? 1 : step_reg;
      ctr = shadow_guide[py * twa_pkg::TileW + px];
      sums = '{default: 0};
      cnt = 0;
      for (int yi = py - rch; yi < py + rch; yi += stp) begin
         for (int xi = px - rch; xi < px + rch; xi += stp) begin
            logic inside_tile;
            inside_tile = xi >= 0 && yi >= 0 && xi < twa_pkg::TileW && yi < twa_pkg::TileH;
            if (inside_tile) g = shadow_guide[yi * twa_pkg::TileW + xi];
            else g = '{default: 16'd0};
            l1_dist = 0;
            for (int c = 0; c < 3; c++)
               l1_dist += (ctr[c] > g[c]) ? ctr[c] - g[c] : g[c] - ctr[c];
            if (l1_dist < threshold_reg) begin
               if (inside_tile)
                  for (int c = 0; c < 4; c++)
                     sums[c] += shadow_color[yi * twa_pkg::TileW + xi][c];
               cnt++;
            end
         end
      end
      if (cnt > 0) begin
         for (int c = 0; c < 4; c++) res.chan[c] = 16'(sums[c] / cnt);
      end else begin
         res.chan[3] = twa_pkg::OneQ412;
      end
      res.count = 9'(cnt);
      return res;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("MISMATCH %s: got %0d, expected %0d", field, got, want);
      error_count++;
   endtask

   // Request side: acceptance is seen at the rising edge, new data at the falling edge.
   logic request_taken = 1'b0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 6000000) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
      request_taken <= req_tvalid && req_tready;
      if (req_tvalid && req_tready)
         expected_averages.push_back(compute_average(current_request));
      if (rsp_tvalid && rsp_tready) begin
         if (expected_averages.size() == 0) begin
            report_mismatch("unexpected response", 1, 0);
         end else begin
            average_result_type w;
            w = expected_averages.pop_front();
            for (int c = 0; c < 4; c++)
               if (rsp_tdata[16*c +: 16] !== w.chan[c])
                  report_mismatch($sformatf("channel %0d", c), rsp_tdata[16*c +: 16], w.chan[c]);
            if (rsp_tdata[72:64] !== w.count)
               report_mismatch("match_count", rsp_tdata[72:64], w.count);
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(99) >= recv_idle_pct;
         if (!req_tvalid || request_taken) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               current_request = pending_requests.pop_front();
               req_tdata <= pack_request(current_request);
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   function automatic pixel_request_type make_request(logic func, int x, int y,
                                                      bit fully_random);
      pixel_request_type r;
      int p;
      r.func = func;
      r.pos_x = 6'(x);
      r.pos_y = 6'(y);
      for (int c = 0; c < 4; c++) r.color[c] = 16'($urandom);
      p = $urandom_range(3);
      for (int c = 0; c < 3; c++) r.guide[c] = fully_random ? 16'($urandom) : palette[p][c];
      return r;
   endfunction

   task automatic write_register(logic [1:0] index, logic [17:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (index)
         twa_pkg::CSR_REACH: reach_reg = value[3:0];
         twa_pkg::CSR_STEP: step_reg = value[2:0];
         twa_pkg::CSR_THRESH: threshold_reg = value;
         default: ;
      endcase
   endtask

   task automatic drain;
      wait (pending_requests.size() == 0 && !req_tvalid && expected_averages.size() == 0);
      repeat (400) @(posedge clock);
   endtask

   initial begin
      pixel_request_type r;
      int unsigned phase_cfg [9][3] = '{
         '{8, 1, 9000}, '{15, 1, 196605}, '{0, 1, 4096}, '{3, 0, 8000},
         '{8, 4, 262143}, '{5, 7, 0}, '{2, 2, 20000}, '{8, 3, 12000}, '{1, 1, 1}
      };
      bit high_corner;
      int cx, cy;
      palette[0] = '{16'd0, 16'd0, 16'd0};
      for (int p = 1; p < 4; p++)
         for (int c = 0; c < 3; c++) palette[p][c] = 16'($urandom_range(8191));
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Filters are centered in the two corner regions below, so their windows
      // only read written pixels or positions off the tile.
      for (int y = 0; y < 24; y++)
         for (int x = 0; x < 24; x++)
            pending_requests.push_back(make_request(1'b0, x, y, $urandom_range(9) == 0));
      for (int y = 48; y < 64; y++)
         for (int x = 48; x < 64; x++)
            pending_requests.push_back(make_request(1'b0, x, y, $urandom_range(9) == 0));
      // Extreme values at the corners, then filters over them.
      r = make_request(1'b0, 0, 0, 0);
      r.color = '{default: 16'hFFFF};
      r.guide = '{default: 16'hFFFF};
      pending_requests.push_back(r);
      r.pos_x = 6'd63; r.pos_y = 6'd63;
      r.color = '{default: 16'h0000};
      r.guide = '{default: 16'h0000};
      pending_requests.push_back(r);
      r.pos_x = 6'd63; r.pos_y = 6'd0;
      r.color = '{default: 16'hFFFF};
      pending_requests.push_back(r);
      foreach (r.color[c]) begin
         pending_requests.push_back(make_request(1'b1, 0, 0, 0));
         pending_requests.push_back(make_request(1'b1, 63, 63, 0));
      end
      drain();

      for (int ph = 0; ph < 9; ph++) begin
         write_register(twa_pkg::CSR_REACH, 18'(phase_cfg[ph][0]));
         write_register(twa_pkg::CSR_STEP, 18'(phase_cfg[ph][1]));
         write_register(twa_pkg::CSR_THRESH, 18'(phase_cfg[ph][2]));
         case (ph / 3)
            0: begin send_idle_pct = 8; recv_idle_pct = 69; end
            1: begin send_idle_pct = 69; recv_idle_pct = 8; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         // Corner filters exercise the window reaching off the tile.
         pending_requests.push_back(make_request(1'b1, 0, 0, 0));
         pending_requests.push_back(make_request(1'b1, 63, 63, 0));
         for (int k = 0; k < 115; k++) begin
            if ($urandom_range(99) < 60) begin
               high_corner = ($urandom_range(1) == 1);
               cx = high_corner ? 56 + int'($urandom_range(7)) : int'($urandom_range(15));
               cy = high_corner ? 56 + int'($urandom_range(7)) : int'($urandom_range(15));
               pending_requests.push_back(make_request(1'b1, cx, cy,
                                                       $urandom_range(9) < 3));
            end else begin
               pending_requests.push_back(make_request(1'b0, $urandom_range(63),
                  $urandom_range(63), $urandom_range(9) < 3));
            end
         end
         drain();
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
